### rtl/spub_pkg.sv
package spub_pkg;

   localparam int PTR_BITS_DEFAULT = 8;

   // input item kinds
   localparam logic [1:0] MODE_SPI     = 2'd0;
   localparam logic [1:0] MODE_UART_RX = 2'd1;
   localparam logic [1:0] MODE_UART_TX = 2'd2;
   localparam logic [1:0] MODE_IDLE    = 2'd3;

   // phase bits of the core's phase register
   localparam logic [7:0] PHASE_CMD_BITS  = 8'hC0;
   localparam logic [7:0] PHASE_RLEN_BITS = 8'h30;
   localparam logic [7:0] PHASE_READ      = 8'h02;
   localparam logic [7:0] PHASE_WRITE     = 8'h01;

   localparam logic [3:0] EXIT_LEN = 4'd12;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_reply;
      logic [7:0] uart_tx_byte;
      logic       uart_tx_valid;
      logic       rx_accepted;
      logic       exit_seen;
   } rsp_type;

   // exit string "JMT+ECHO=0" CR LF, one character per index
   function automatic logic [7:0] exit_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h4A;
         4'd1:    c = 8'h4D;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h2B;
         4'd4:    c = 8'h45;
         4'd5:    c = 8'h43;
         4'd6:    c = 8'h48;
         4'd7:    c = 8'h4F;
         4'd8:    c = 8'h3D;
         4'd9:    c = 8'h30;
         4'd10:   c = 8'h0D;
         4'd11:   c = 8'h0A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/spi_uart_bridge_slave.sv
// SPI slave / UART bridge. Each req transfer reports one event: an SPI byte
// exchanged (mode 0), a UART byte received (mode 1), a free UART transmit slot
// (mode 2) or nothing (mode 3); each yields exactly one rsp transfer. UART rx
// bytes go into the read ring (dropped when full) and are scanned for the exit
// string; transmit slots drain the write ring. SPI transactions open with a
// command byte (bit 7 read, bit 6 write), then write length, then read length
// (clamped to bytes stored), followed by data bytes; the command and write
// length bytes are answered with the read and write ring counts. An item is
// held in in_ff, then out_ff; one item per cycle is sustained while rsp_ready
// holds, as each ring's single registered read port prefetches the tail entry.
// Ring contents are not cleared at reset and no clearing pass runs; the block
// is ready right after reset.
module spi_uart_bridge_slave #(
   parameter int PTR_BITS = spub_pkg::PTR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spub_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spub_pkg::rsp_type rsp_data
);

   // input register
   spub_pkg::req_type in_ff;
   logic              in_valid_ff;

   // result register
   spub_pkg::rsp_type out_ff;
   logic              out_valid_ff;

   spub_pkg::rsp_type   result;
   logic                advance;
   logic                rd_ring_we, wr_ring_we;
   logic [PTR_BITS-1:0] rd_ring_waddr, rd_ring_raddr;
   logic [PTR_BITS-1:0] wr_ring_waddr, wr_ring_raddr;
   logic [7:0]          rd_ring_q, wr_ring_q;

   // item moves from input register to result register when the latter frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   spub_core #(
      .PTR_BITS (PTR_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_ff),
      .rd_ring_q     (rd_ring_q),
      .wr_ring_q     (wr_ring_q),
      .result        (result),
      .rd_ring_we    (rd_ring_we),
      .rd_ring_waddr (rd_ring_waddr),
      .rd_ring_raddr (rd_ring_raddr),
      .wr_ring_we    (wr_ring_we),
      .wr_ring_waddr (wr_ring_waddr),
      .wr_ring_raddr (wr_ring_raddr)
   );

   // UART to SPI
   spub_ring #(
      .PTR_BITS (PTR_BITS)
   ) u_read_ring (
      .clock (clock),
      .we    (rd_ring_we),
      .waddr (rd_ring_waddr),
      .wdata (in_ff.data_byte),
      .raddr (rd_ring_raddr),
      .rdata (rd_ring_q)
   );

   // SPI to UART
   spub_ring #(
      .PTR_BITS (PTR_BITS)
   ) u_write_ring (
      .clock (clock),
      .we    (wr_ring_we),
      .waddr (wr_ring_waddr),
      .wdata (in_ff.data_byte),
      .raddr (wr_ring_raddr),
      .rdata (wr_ring_q)
   );

endmodule

### rtl/spub_ring.sv
// Byte ring storage: one write port, one registered read port.
// A write to the address being read is forwarded, so rdata always
// reflects the entry at the last read address after the edge.
module spub_ring #(
   parameter int PTR_BITS = spub_pkg::PTR_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                we,
   input  logic [PTR_BITS-1:0] waddr,
   input  logic [7:0]          wdata,
   input  logic [PTR_BITS-1:0] raddr,
   output logic [7:0]          rdata
);

   localparam int DEPTH = 1 << PTR_BITS;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/spub_core.sv
// Bridge state and the single-pass step logic for one item.
module spub_core #(
   parameter int PTR_BITS = spub_pkg::PTR_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  spub_pkg::req_type   item,
   input  logic [7:0]          rd_ring_q,
   input  logic [7:0]          wr_ring_q,
   output spub_pkg::rsp_type   result,
   output logic                rd_ring_we,
   output logic [PTR_BITS-1:0] rd_ring_waddr,
   output logic [PTR_BITS-1:0] rd_ring_raddr,
   output logic                wr_ring_we,
   output logic [PTR_BITS-1:0] wr_ring_waddr,
   output logic [PTR_BITS-1:0] wr_ring_raddr
);

   localparam logic [PTR_BITS-1:0] PTR_ONE = PTR_BITS'(1);

   logic [7:0]          phase_ff, phase_in;
   logic [7:0]          write_len_ff, write_len_in;
   logic [7:0]          read_len_ff, read_len_in;
   logic [PTR_BITS-1:0] read_head_ff, read_head_in;
   logic [PTR_BITS-1:0] read_tail_ff, read_tail_in;
   logic [PTR_BITS-1:0] write_head_ff, write_head_in;
   logic [PTR_BITS-1:0] write_tail_ff, write_tail_in;
   logic [3:0]          match_ff, match_in;

   logic [7:0] read_count;
   logic [7:0] write_count;
   logic [7:0] read_clamp;
   logic [7:0] read_base;
   logic [7:0] write_dec;
   logic       take_read;

   assign read_count  = 8'(PTR_BITS'(read_head_ff - read_tail_ff));
   assign write_count = 8'(PTR_BITS'(write_head_ff - write_tail_ff));
   assign read_clamp  = (item.data_byte > read_count) ? read_count : item.data_byte;

   always_comb begin
      phase_in      = phase_ff;
      write_len_in  = write_len_ff;
      read_len_in   = read_len_ff;
      read_head_in  = read_head_ff;
      read_tail_in  = read_tail_ff;
      write_head_in = write_head_ff;
      write_tail_in = write_tail_ff;
      match_in      = match_ff;
      result        = '0;
      rd_ring_we    = 1'b0;
      wr_ring_we    = 1'b0;
      take_read     = 1'b0;
      read_base     = 8'h00;
      write_dec     = 8'h00;

      if (advance) begin
         unique case (item.mode)
            spub_pkg::MODE_SPI: begin
               priority if (phase_ff == 8'h00) begin
                  // command byte
                  phase_in         = item.data_byte & spub_pkg::PHASE_CMD_BITS;
                  result.spi_reply = read_count;
               end else if ((phase_ff & spub_pkg::PHASE_CMD_BITS) != 8'h00) begin
                  // write length byte
                  phase_in         = phase_ff >> 2;
                  write_len_in     = item.data_byte;
                  result.spi_reply = write_count;
               end else if ((phase_ff & spub_pkg::PHASE_RLEN_BITS) != 8'h00) begin
                  // read length byte, clamped to what is stored
                  phase_in    = phase_ff >> 4;
                  read_len_in = read_clamp;
                  if (write_len_ff == 8'h00) begin
                     phase_in = phase_in & ~spub_pkg::PHASE_WRITE;
                  end
                  if (read_clamp == 8'h00) begin
                     // nothing loaded: received byte shifts back out
                     phase_in         = phase_in & ~spub_pkg::PHASE_READ;
                     result.spi_reply = item.data_byte;
                  end else begin
                     take_read = 1'b1;
                     read_base = read_clamp;
                  end
               end else begin
                  // data phase
                  if ((phase_ff & spub_pkg::PHASE_READ) != 8'h00) begin
                     take_read = 1'b1;
                     read_base = read_len_ff;
                  end
                  if ((phase_ff & spub_pkg::PHASE_WRITE) != 8'h00) begin
                     wr_ring_we = 1'b1;
                     // full ring: overwrite the free slot, head holds
                     if ((write_head_ff + PTR_ONE) != write_tail_ff) begin
                        write_head_in = write_head_ff + PTR_ONE;
                     end
                     write_dec    = (write_len_ff != 8'h00) ? write_len_ff - 8'd1 : 8'h00;
                     write_len_in = write_dec;
                     if (write_dec == 8'h00) begin
                        phase_in = phase_in & ~spub_pkg::PHASE_WRITE;
                     end
                  end
               end

               if (take_read) begin
                  result.spi_reply = rd_ring_q;
                  if (read_tail_ff != read_head_ff) begin
                     read_tail_in = read_tail_ff + PTR_ONE;
                  end
                  read_len_in = (read_base != 8'h00) ? read_base - 8'd1 : 8'h00;
                  if (read_len_in == 8'h00) begin
                     phase_in = phase_in & ~spub_pkg::PHASE_READ;
                  end
               end
            end

            spub_pkg::MODE_UART_RX: begin
               if ((read_head_ff + PTR_ONE) != read_tail_ff) begin
                  rd_ring_we         = 1'b1;
                  result.rx_accepted = 1'b1;
                  if ((match_ff < spub_pkg::EXIT_LEN) &&
                      (item.data_byte == spub_pkg::exit_char(match_ff))) begin
                     if (match_ff == (spub_pkg::EXIT_LEN - 4'd1)) begin
                        result.exit_seen = 1'b1;
                        match_in         = 4'd0;
                     end else begin
                        match_in = match_ff + 4'd1;
                     end
                  end else begin
                     match_in = 4'd0;
                  end
                  read_head_in = read_head_ff + PTR_ONE;
               end
            end

            spub_pkg::MODE_UART_TX: begin
               if (write_tail_ff != write_head_ff) begin
                  result.uart_tx_byte  = wr_ring_q;
                  result.uart_tx_valid = 1'b1;
                  write_tail_in        = write_tail_ff + PTR_ONE;
               end
            end

            spub_pkg::MODE_IDLE: begin
            end
         endcase
      end
   end

   assign rd_ring_waddr = read_head_ff;
   assign rd_ring_raddr = read_tail_in;
   assign wr_ring_waddr = write_head_ff;
   assign wr_ring_raddr = write_tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 8'h00;
         write_len_ff  <= 8'h00;
         read_len_ff   <= 8'h00;
         read_head_ff  <= '0;
         read_tail_ff  <= '0;
         write_head_ff <= '0;
         write_tail_ff <= '0;
         match_ff      <= 4'd0;
      end else begin
         phase_ff      <= phase_in;
         write_len_ff  <= write_len_in;
         read_len_ff   <= read_len_in;
         read_head_ff  <= read_head_in;
         read_tail_ff  <= read_tail_in;
         write_head_ff <= write_head_in;
         write_tail_ff <= write_tail_in;
         match_ff      <= match_in;
      end
   end

endmodule
